// File: rtl/pcs_pkg.sv
// Shared constants, tables and types of the piecewise-linear contrast stretch core.
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

   localparam int SampleBits   = 16;
   localparam int ReqDataBits  = ((SampleBits + 7) / 8) * 8;
   localparam int WideBits     = 33;
   localparam int RangeBits    = 15;
   localparam int GainBits     = 24;
   localparam int NumBits      = GainBits + RangeBits;
   localparam int FracBits     = 16;
   localparam int LevelBits    = 25;
   localparam int DivSteps     = LevelBits;
   localparam int PixelBits    = 8;
   localparam int Segments     = 5;
   localparam int SegBits      = 3;
   localparam int SlopeBits    = 7;
   localparam int DxBits       = 7;
   localparam int ProdBits     = LevelBits + SlopeBits;
   localparam int TermBits     = 13;
   localparam int TermXBits    = TermBits + 1;
   localparam int RecipBits    = 16;
   localparam int RecipShift   = 20;
   localparam int RprodBits    = TermBits + RecipBits;
   localparam int QuotBits     = RprodBits - RecipShift;
   localparam int ResBits      = QuotBits + 1;
   localparam int CurveStages  = 5;
   localparam int BufDepth     = 2;
   localparam int BufCountBits = 2;
   localparam int RegIndexBits = 1;

   localparam logic [WideBits-1:0]  NodataLimit    = WideBits'(32760);
   localparam logic [GainBits-1:0]  Gain           = GainBits'(16711673);
   localparam logic [LevelBits-1:0] LevelOne       = LevelBits'(65536);
   localparam logic [LevelBits-1:0] LevelMax       = '1;
   localparam logic [RangeBits-1:0] RangeLowReset  = RangeBits'(0);
   localparam logic [RangeBits-1:0] RangeHighReset = RangeBits'(32759);
   localparam logic [PixelBits-1:0] PixelMax       = '1;

   typedef enum logic [RegIndexBits-1:0] {
      REG_RANGE_LOW  = 1'b0,
      REG_RANGE_HIGH = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic                 nodata;
      logic                 neg;
      logic                 dzero;
      logic                 ovf;
      logic [RangeBits-1:0] dmag;
   } side_type;

   typedef struct packed {
      side_type             side;
      logic [RangeBits-1:0] rem;
      logic [LevelBits-1:0] work;
   } div_stage_type;

   function automatic logic [PixelBits-1:0] knot_x(input logic [SegBits-1:0] idx);
      logic [PixelBits-1:0] r;
      case (idx)
         3'd0:    r = 8'd0;
         3'd1:    r = 8'd30;
         3'd2:    r = 8'd60;
         3'd3:    r = 8'd120;
         3'd4:    r = 8'd190;
         3'd5:    r = 8'd255;
         default: r = 8'd255;
      endcase
      return r;
   endfunction

   function automatic logic [PixelBits-1:0] knot_y(input logic [SegBits-1:0] idx);
      logic [PixelBits-1:0] r;
      case (idx)
         3'd0:    r = 8'd0;
         3'd1:    r = 8'd110;
         3'd2:    r = 8'd160;
         3'd3:    r = 8'd210;
         3'd4:    r = 8'd240;
         3'd5:    r = 8'd255;
         default: r = 8'd255;
      endcase
      return r;
   endfunction

   function automatic logic [LevelBits-1:0] knot_level(input logic [SegBits-1:0] idx);
      return LevelBits'({knot_x(idx), {FracBits{1'b0}}});
   endfunction

   function automatic logic [DxBits-1:0] seg_dx(input logic [SegBits-1:0] seg);
      return DxBits'(knot_x(seg + 3'd1) - knot_x(seg));
   endfunction

   function automatic logic [SlopeBits-1:0] seg_dy(input logic [SegBits-1:0] seg);
      return SlopeBits'(knot_y(seg + 3'd1) - knot_y(seg));
   endfunction

   // floor(2^20 / dx) for each segment
   function automatic logic [RecipBits-1:0] seg_recip(input logic [SegBits-1:0] seg);
      logic [RecipBits-1:0] r;
      case (seg)
         3'd0:    r = 16'd34952;
         3'd1:    r = 16'd34952;
         3'd2:    r = 16'd17476;
         3'd3:    r = 16'd14979;
         3'd4:    r = 16'd16131;
         default: r = 16'd16131;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/pcs_front.sv
// Range registers, sample offset and span, gain multiply and overflow check.
`timescale 1ns / 1ps
`default_nettype none

module pcs_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic [pcs_pkg::SampleBits-1:0]      sample,
   input  logic                                csr_we,
   input  logic [pcs_pkg::RegIndexBits-1:0]    csr_addr,
   input  logic [pcs_pkg::RangeBits-1:0]       csr_wdata,
   output logic                                out_valid,
   output pcs_pkg::div_stage_type              out_data
);
   import pcs_pkg::*;

   logic [RangeBits-1:0] range_low_ff;
   logic [RangeBits-1:0] range_high_ff;

   logic [WideBits-1:0]  wide_sample;
   logic [RangeBits:0]   diff;
   logic [RangeBits:0]   span;
   side_type             s1_side_in;
   logic [RangeBits-1:0] s1_xmag_in;
   logic                 s1_valid_ff;
   side_type             s1_side_ff;
   logic [RangeBits-1:0] s1_xmag_ff;

   logic [NumBits-1:0]   s2_num_in;
   logic                 s2_valid_ff;
   side_type             s2_side_ff;
   logic [NumBits-1:0]   s2_num_ff;

   div_stage_type        s3_in;
   logic                 s3_valid_ff;
   div_stage_type        s3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= RangeLowReset;
         range_high_ff <= RangeHighReset;
      end else if (csr_we) begin
         case (csr_addr)
            REG_RANGE_LOW:  range_low_ff  <= csr_wdata;
            REG_RANGE_HIGH: range_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid samples fit in the range width, so the low bits are exact
   always_comb begin
      wide_sample       = WideBits'(sample);
      diff              = {1'b0, wide_sample[RangeBits-1:0]} - {1'b0, range_low_ff};
      span              = {1'b0, range_high_ff} - {1'b0, range_low_ff};
      s1_side_in.nodata = wide_sample > NodataLimit;
      s1_side_in.neg    = diff[RangeBits] ^ span[RangeBits];
      s1_side_in.dzero  = span == '0;
      s1_side_in.ovf    = 1'b0;
      s1_side_in.dmag   = span[RangeBits] ? RangeBits'(-span) : span[RangeBits-1:0];
      s1_xmag_in        = diff[RangeBits] ? RangeBits'(-diff) : diff[RangeBits-1:0];
   end

   assign s2_num_in = NumBits'(Gain) * NumBits'(s1_xmag_ff);

   // quotient of 2^25 or more saturates the level either way
   always_comb begin
      s3_in          = '0;
      s3_in.side     = s2_side_ff;
      s3_in.side.ovf = {1'b0, s2_num_ff[NumBits-1:LevelBits]} >= s2_side_ff.dmag;
      s3_in.rem      = RangeBits'(s2_num_ff[NumBits-1:LevelBits]);
      s3_in.work     = s2_num_ff[LevelBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_side_ff <= s1_side_in;
         s1_xmag_ff <= s1_xmag_in;
         s2_side_ff <= s1_side_ff;
         s2_num_ff  <= s2_num_in;
         s3_ff      <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

endmodule

`default_nettype wire

// File: rtl/pcs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module pcs_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  pcs_pkg::div_stage_type in_data,
   output logic                   out_valid,
   output pcs_pkg::div_stage_type out_data
);
   import pcs_pkg::*;

   logic          valid_ff [DivSteps];
   div_stage_type stage_ff [DivSteps];

   for (genvar k = 0; k < DivSteps; k++) begin : g_step
      div_stage_type      src;
      logic               src_valid;
      logic [RangeBits:0] trial;
      logic               fits;
      div_stage_type      stage_in;

      if (k == 0) begin : g_first
         assign src       = in_data;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src       = stage_ff[k-1];
         assign src_valid = valid_ff[k-1];
      end

      always_comb begin
         trial          = {src.rem, src.work[LevelBits-1]};
         fits           = trial >= {1'b0, src.side.dmag};
         stage_in       = src;
         stage_in.work  = {src.work[LevelBits-2:0], fits};
         stage_in.rem   = fits ? RangeBits'(trial - {1'b0, src.side.dmag})
                               : trial[RangeBits-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            stage_ff[k] <= stage_in;
         end
      end
   end

   assign out_valid = valid_ff[DivSteps-1];
   assign out_data  = stage_ff[DivSteps-1];

endmodule

`default_nettype wire

// File: rtl/pcs_curve.sv
// Level saturation and the five-segment tone curve.
`timescale 1ns / 1ps
`default_nettype none

module pcs_curve (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  pcs_pkg::div_stage_type         in_data,
   output logic                           out_valid,
   output logic [pcs_pkg::PixelBits-1:0]  out_pixel
);
   import pcs_pkg::*;

   logic [CurveStages-1:0] valid_ff;
   logic [CurveStages-1:0] nodata_ff;

   logic [LevelBits:0]     sum;
   logic [LevelBits-1:0]   level_in;
   logic [LevelBits-1:0]   level_ff;

   logic [SegBits-1:0]     seg_in;
   logic [LevelBits-1:0]   off_in;
   logic [SegBits-1:0]     c2_seg_ff;
   logic [LevelBits-1:0]   off_ff;

   logic [ProdBits-1:0]    prod;
   logic [SegBits-1:0]     c3_seg_ff;
   logic [TermBits-1:0]    c3_term_ff;

   logic [RprodBits-1:0]   rprod;
   logic [SegBits-1:0]     c4_seg_ff;
   logic [TermBits-1:0]    c4_term_ff;
   logic [QuotBits-1:0]    quot_ff;

   logic [TermXBits-1:0]   back;
   logic [TermXBits-1:0]   rest;
   logic [ResBits-1:0]     quot_fix;
   logic [ResBits-1:0]     res;
   logic [PixelBits-1:0]   pixel_in;
   logic [PixelBits-1:0]   pixel_ff;

   always_comb begin
      sum = {1'b0, LevelOne} + {1'b0, in_data.work};
      if (in_data.side.dzero) begin
         level_in = LevelOne;
      end else if (in_data.side.ovf) begin
         level_in = in_data.side.neg ? '0 : LevelMax;
      end else if (in_data.side.neg) begin
         level_in = (in_data.work > LevelOne) ? '0 : LevelOne - in_data.work;
      end else begin
         level_in = (sum > {1'b0, LevelMax}) ? LevelMax : sum[LevelBits-1:0];
      end
   end

   // first segment whose upper knot is not below the level; last one extends
   always_comb begin
      seg_in = SegBits'(Segments - 1);
      for (int i = Segments - 2; i >= 0; i--) begin
         if (level_ff <= knot_level(SegBits'(i + 1))) begin
            seg_in = SegBits'(i);
         end
      end
      off_in = level_ff - knot_level(seg_in);
   end

   assign prod  = ProdBits'(off_ff) * ProdBits'(seg_dy(c2_seg_ff));
   assign rprod = RprodBits'(c3_term_ff) * RprodBits'(seg_recip(c3_seg_ff));

   // reciprocal estimate is low by at most one
   always_comb begin
      back     = TermXBits'(quot_ff) * TermXBits'(seg_dx(c4_seg_ff));
      rest     = {1'b0, c4_term_ff} - back;
      quot_fix = ResBits'(quot_ff) + ResBits'(rest >= TermXBits'(seg_dx(c4_seg_ff)));
      res      = ResBits'(knot_y(c4_seg_ff)) + quot_fix;
      if (nodata_ff[3]) begin
         pixel_in = '0;
      end else if (res > ResBits'(PixelMax)) begin
         pixel_in = PixelMax;
      end else begin
         pixel_in = res[PixelBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[CurveStages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nodata_ff  <= {nodata_ff[CurveStages-2:0], in_data.side.nodata};
         level_ff   <= level_in;
         c2_seg_ff  <= seg_in;
         off_ff     <= off_in;
         c3_seg_ff  <= c2_seg_ff;
         c3_term_ff <= prod[FracBits+TermBits-1:FracBits];
         c4_seg_ff  <= c3_seg_ff;
         c4_term_ff <= c3_term_ff;
         quot_ff    <= rprod[RprodBits-1:RecipShift];
         pixel_ff   <= pixel_in;
      end
   end

   assign out_valid = valid_ff[CurveStages-1];
   assign out_pixel = pixel_ff;

endmodule

`default_nettype wire

// File: rtl/pcs_out_buf.sv
// Two-entry output buffer between the pipeline and the result channel.
`timescale 1ns / 1ps
`default_nettype none

module pcs_out_buf (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [pcs_pkg::PixelBits-1:0]  push_pixel,
   output logic                           full,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [pcs_pkg::PixelBits-1:0]  rsp_pixel
);
   import pcs_pkg::*;

   logic [BufCountBits-1:0] count_ff;
   logic [BufCountBits-1:0] count_in;
   logic [PixelBits-1:0]    head_ff;
   logic [PixelBits-1:0]    head_in;
   logic [PixelBits-1:0]    tail_ff;
   logic [PixelBits-1:0]    tail_in;
   logic                    pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign full       = count_ff == BufCountBits'(BufDepth);
   assign rsp_tvalid = count_ff != '0;
   assign rsp_pixel  = head_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == '0) begin
               head_in = push_pixel;
            end else begin
               tail_in = push_pixel;
            end
            count_in = count_ff + BufCountBits'(1);
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - BufCountBits'(1);
         end
         2'b11: begin
            if (count_ff == BufCountBits'(1)) begin
               head_in = push_pixel;
            end else begin
               head_in = tail_ff;
               tail_in = push_pixel;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

// File: rtl/piecewise_linear_contrast_stretch_core.sv
// Top level of the piecewise-linear contrast stretch core.
// Takes one raw sample per item and returns one stretched 8-bit pixel per item. Samples above
// 32760 are nodata and give 0; others are normalized against the range_low/range_high registers
// to a Q9.16 level and mapped through a fixed five-segment curve. An item can be taken every
// cycle; results reach the result port through 3 front stages (offset,
// gain multiply, overflow check), 25 divider stages (one quotient bit each) and 5 curve stages,
// plus the output buffer. The whole pipeline stalls only while the two-entry output buffer is
// full. Write range registers only while no items are in flight.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_contrast_stretch_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pcs_pkg::ReqDataBits-1:0]     req_tdata,   // [SampleBits-1:0] sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pcs_pkg::PixelBits-1:0]       rsp_tdata,   // [7:0] pixel
   input  logic                                csr_we,
   input  logic [pcs_pkg::RegIndexBits-1:0]    csr_addr,
   input  logic [pcs_pkg::RangeBits-1:0]       csr_wdata
);
   import pcs_pkg::*;

   logic          adv;
   logic          buf_full;
   logic          front_valid;
   div_stage_type front_data;
   logic          div_valid;
   div_stage_type div_data;
   logic          curve_valid;
   logic [PixelBits-1:0] curve_pixel;

   assign adv        = !buf_full;
   assign req_tready = adv;

   pcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .sample    (req_tdata[SampleBits-1:0]),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   pcs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   pcs_curve u_curve (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (curve_valid),
      .out_pixel (curve_pixel)
   );

   pcs_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (curve_valid && adv),
      .push_pixel (curve_pixel),
      .full       (buf_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_pixel  (rsp_tdata)
   );

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      div_valid && !div_data.side.dzero && !div_data.side.ovf
         |-> div_data.rem < div_data.side.dmag)
      else $error("divider remainder not below divisor");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(div_data) && $stable(div_valid) && $stable(front_data))
      else $error("pipeline moved during stall");

endmodule

`default_nettype wire
